### hw/rtl/pffa_pkg.sv
// ----------------------------------------------------------------------------
// pffa_pkg
// Shared types and codes for the paged first-fit allocator.
// ----------------------------------------------------------------------------
package pffa_pkg;

   // transaction kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // response status codes
   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_FAILED  = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   // fixed field widths
   localparam int REQ_BYTES_W  = 16;
   localparam int PAGE_NUM_W   = 4;
   localparam int BYTE_OFF_W   = 12;
   localparam int FREE_TOTAL_W = 17;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ASCAN,
      ST_NEWPG,
      ST_CARVE,
      ST_CARVE_HEAD,
      ST_FSCAN,
      ST_MSTART,
      ST_MCUR,
      ST_MNEXT
   } state_type;

endpackage

### hw/rtl/paged_first_fit_allocator_unit.sv
// ----------------------------------------------------------------------------
// paged_first_fit_allocator_unit
// First-fit heap over PAGES pages with block split on allocate and merging of
// adjacent free blocks on free, walked one block header per cycle.
// ----------------------------------------------------------------------------
//  channel  | ports                               | handshake
//  request  | req_kind/request_bytes/page/offset  | start high while busy low
//  response | rsp_status/result_*/free_total      | rsp_strobe, one cycle, no stall
//
// An allocate walks the block headers of the open pages, opens a new page
// (ST_NEWPG) when none fits, then carves the block (ST_CARVE, ST_CARVE_HEAD);
// a free walks the blocks up to the target, restarts at the page base and walks
// that page again, merging free neighbours. The header memory allows one read
// and one write a cycle. Synchronous reset empties the heap at once; no clearing
// pass is needed. The response cannot be stalled.
module paged_first_fit_allocator_unit #(
   parameter int PAGES        = 16,
   parameter int PAGE_BYTES   = 4096,
   parameter int HEADER_BYTES = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_kind,
   input  logic [pffa_pkg::REQ_BYTES_W-1:0]      req_request_bytes,
   input  logic [pffa_pkg::PAGE_NUM_W-1:0]       req_page_number,
   input  logic [pffa_pkg::BYTE_OFF_W-1:0]       req_byte_offset,
   output logic                                  rsp_strobe,
   output logic [1:0]                            rsp_status,
   output logic [pffa_pkg::PAGE_NUM_W-1:0]       rsp_result_page,
   output logic [pffa_pkg::BYTE_OFF_W-1:0]       rsp_result_offset,
   output logic [pffa_pkg::FREE_TOTAL_W-1:0]     rsp_free_total
);

   localparam int PW  = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int UW  = PW + 1;
   localparam int OW  = $clog2(PAGE_BYTES);
   localparam int SZW = OW + 1;
   localparam int AW  = PW + OW;
   localparam int NW  = pffa_pkg::REQ_BYTES_W + 2;
   localparam int FTW = pffa_pkg::FREE_TOTAL_W;
   localparam logic [SZW-1:0] PAGE_SZ = SZW'(PAGE_BYTES);

   // header memory: {free flag, block size} at every byte position
   logic [SZW:0] mem [0:(1<<AW)-1];
   logic [SZW:0] rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [SZW:0]  mem_wdata;
   logic [AW-1:0] mem_raddr;

   pffa_pkg::state_type state_ff, state_in;
   logic [SZW-1:0] need_ff, need_in;
   logic [OW-1:0]  target_ff, target_in;
   logic [PW-1:0]  page_ff, page_in;
   logic [OW-1:0]  off_ff, off_in;
   logic [SZW-1:0] cur_sz_ff, cur_sz_in;
   logic           cur_free_ff, cur_free_in;
   logic [UW-1:0]  used_ff, used_in;
   logic [FTW-1:0] ft_ff, ft_in;
   logic           strobe_ff, strobe_in;
   logic [1:0]     status_ff, status_in;
   logic [pffa_pkg::PAGE_NUM_W-1:0] rpage_ff, rpage_in;
   logic [pffa_pkg::BYTE_OFF_W-1:0] roff_ff, roff_in;

   // decoded header read and request arithmetic
   logic [SZW-1:0] rd_sz;
   logic           rd_free;
   logic [NW-1:0]  need_full;
   logic [OW:0]    nx_rd;
   logic [OW:0]    nx_merge;
   logic [SZW:0]   split_min;
   logic [SZW-1:0] merged_sz;
   logic [pffa_pkg::BYTE_OFF_W-1:0] free_a;

   assign rd_sz     = rdata_ff[SZW-1:0];
   assign rd_free   = rdata_ff[SZW];
   assign need_full = NW'((req_request_bytes + 18'd3) & ~18'd3) + NW'(HEADER_BYTES);
   assign nx_rd     = (OW+1)'(off_ff) + rd_sz;
   assign merged_sz = cur_sz_ff + rd_sz;
   assign nx_merge  = (OW+1)'(off_ff) + merged_sz;
   assign split_min = (SZW+1)'(need_ff) + (SZW+1)'(HEADER_BYTES + 4);
   assign free_a    = req_byte_offset - pffa_pkg::BYTE_OFF_W'(HEADER_BYTES);

   // header memory ports
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rdata_ff <= mem[mem_raddr];
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pffa_pkg::ST_IDLE;
         used_ff   <= '0;
         ft_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         used_ff   <= used_in;
         ft_ff     <= ft_in;
         strobe_ff <= strobe_in;
      end
   end

   // working and response payload registers
   always_ff @(posedge clock) begin
      need_ff     <= need_in;
      target_ff   <= target_in;
      page_ff     <= page_in;
      off_ff      <= off_in;
      cur_sz_ff   <= cur_sz_in;
      cur_free_ff <= cur_free_in;
      status_ff   <= status_in;
      rpage_ff    <= rpage_in;
      roff_ff     <= roff_in;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      need_in     = need_ff;
      target_in   = target_ff;
      page_in     = page_ff;
      off_in      = off_ff;
      cur_sz_in   = cur_sz_ff;
      cur_free_in = cur_free_ff;
      used_in     = used_ff;
      ft_in       = ft_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      rpage_in    = rpage_ff;
      roff_in     = roff_ff;
      mem_we      = 1'b0;
      mem_waddr   = {page_ff, off_ff};
      mem_wdata   = '0;
      mem_raddr   = {page_ff, off_ff};

      case (state_ff)
         pffa_pkg::ST_IDLE: begin
            if (start) begin
               page_in   = '0;
               off_in    = '0;
               mem_raddr = '0;
               status_in = pffa_pkg::STATUS_DONE;
               rpage_in  = '0;
               roff_in   = '0;
               if (req_kind == pffa_pkg::KIND_ALLOC) begin
                  need_in = SZW'(need_full);
                  if (req_request_bytes == '0 || need_full > NW'(PAGE_BYTES)) begin
                     status_in = pffa_pkg::STATUS_FAILED;
                     strobe_in = 1'b1;
                  end else if (used_ff == '0) begin
                     state_in = pffa_pkg::ST_NEWPG;
                  end else begin
                     state_in = pffa_pkg::ST_ASCAN;
                  end
               end else begin
                  page_in   = PW'(req_page_number);
                  target_in = OW'(free_a);
                  mem_raddr = {PW'(req_page_number), {OW{1'b0}}};
                  if (32'(req_page_number) >= 32'(used_ff) ||
                      32'(req_byte_offset) < HEADER_BYTES ||
                      32'(free_a) >= PAGE_BYTES) begin
                     status_in = pffa_pkg::STATUS_IGNORED;
                     strobe_in = 1'b1;
                  end else begin
                     state_in = pffa_pkg::ST_FSCAN;
                  end
               end
            end
         end

         // first-fit walk, one header per cycle
         pffa_pkg::ST_ASCAN: begin
            if (rd_free && rd_sz >= need_ff) begin
               cur_sz_in = rd_sz;
               state_in  = pffa_pkg::ST_CARVE;
            end else if (nx_rd >= (OW+1)'(PAGE_BYTES)) begin
               page_in   = page_ff + 1'b1;
               off_in    = '0;
               mem_raddr = {page_ff + 1'b1, {OW{1'b0}}};
               if (UW'(page_ff) + 1'b1 == used_ff) state_in = pffa_pkg::ST_NEWPG;
            end else begin
               off_in    = OW'(nx_rd);
               mem_raddr = {page_ff, OW'(nx_rd)};
            end
         end

         // open a fresh page holding one free block, or fail when all pages are used
         pffa_pkg::ST_NEWPG: begin
            if (32'(used_ff) >= PAGES) begin
               status_in = pffa_pkg::STATUS_FAILED;
               strobe_in = 1'b1;
               state_in  = pffa_pkg::ST_IDLE;
            end else begin
               page_in   = PW'(used_ff);
               used_in   = used_ff + 1'b1;
               ft_in     = ft_ff + FTW'(PAGE_BYTES);
               off_in    = '0;
               cur_sz_in = PAGE_SZ;
               state_in  = pffa_pkg::ST_CARVE;
            end
         end

         // split off the tail when enough remains
         pffa_pkg::ST_CARVE: begin
            if ((SZW+1)'(cur_sz_ff) >= split_min) begin
               mem_we    = 1'b1;
               mem_waddr = {page_ff, off_ff + OW'(need_ff)};
               mem_wdata = {1'b1, cur_sz_ff - need_ff};
               cur_sz_in = need_ff;
            end
            state_in = pffa_pkg::ST_CARVE_HEAD;
         end

         // mark the taken block used and respond
         pffa_pkg::ST_CARVE_HEAD: begin
            mem_we    = 1'b1;
            mem_waddr = {page_ff, off_ff};
            mem_wdata = {1'b0, cur_sz_ff};
            ft_in     = ft_ff - FTW'(cur_sz_ff);
            status_in = pffa_pkg::STATUS_DONE;
            rpage_in  = pffa_pkg::PAGE_NUM_W'(page_ff);
            roff_in   = pffa_pkg::BYTE_OFF_W'(32'(off_ff) + HEADER_BYTES);
            strobe_in = 1'b1;
            state_in  = pffa_pkg::ST_IDLE;
         end

         // walk the page to find the block being freed
         pffa_pkg::ST_FSCAN: begin
            if (off_ff == target_ff) begin
               if (rd_free) begin
                  status_in = pffa_pkg::STATUS_IGNORED;
                  strobe_in = 1'b1;
                  state_in  = pffa_pkg::ST_IDLE;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = {page_ff, off_ff};
                  mem_wdata = {1'b1, rd_sz};
                  ft_in     = ft_ff + FTW'(rd_sz);
                  state_in  = pffa_pkg::ST_MSTART;
               end
            end else if (nx_rd > (OW+1)'(target_ff)) begin
               status_in = pffa_pkg::STATUS_IGNORED;
               strobe_in = 1'b1;
               state_in  = pffa_pkg::ST_IDLE;
            end else begin
               off_in    = OW'(nx_rd);
               mem_raddr = {page_ff, OW'(nx_rd)};
            end
         end

         // restart at the page base for merging
         pffa_pkg::ST_MSTART: begin
            off_in    = '0;
            mem_raddr = {page_ff, {OW{1'b0}}};
            state_in  = pffa_pkg::ST_MCUR;
         end

         // first block of the merge walk
         pffa_pkg::ST_MCUR: begin
            cur_sz_in   = rd_sz;
            cur_free_in = rd_free;
            if (nx_rd >= (OW+1)'(PAGE_BYTES)) begin
               strobe_in = 1'b1;
               state_in  = pffa_pkg::ST_IDLE;
            end else begin
               mem_raddr = {page_ff, OW'(nx_rd)};
               state_in  = pffa_pkg::ST_MNEXT;
            end
         end

         // next block is in rdata: merge into current or advance
         pffa_pkg::ST_MNEXT: begin
            if (cur_free_ff && rd_free) begin
               mem_we    = 1'b1;
               mem_waddr = {page_ff, off_ff};
               mem_wdata = {1'b1, merged_sz};
               cur_sz_in = merged_sz;
               if (nx_merge >= (OW+1)'(PAGE_BYTES)) begin
                  strobe_in = 1'b1;
                  state_in  = pffa_pkg::ST_IDLE;
               end else begin
                  mem_raddr = {page_ff, OW'(nx_merge)};
               end
            end else begin
               off_in      = OW'((OW+1)'(off_ff) + cur_sz_ff);
               cur_sz_in   = rd_sz;
               cur_free_in = rd_free;
               if ((OW+1)'(off_in) + rd_sz >= (OW+1)'(PAGE_BYTES)) begin
                  strobe_in = 1'b1;
                  state_in  = pffa_pkg::ST_IDLE;
               end else begin
                  mem_raddr = {page_ff, OW'((OW+1)'(off_in) + rd_sz)};
               end
            end
         end

         default: state_in = pffa_pkg::ST_IDLE;
      endcase
   end

   assign busy              = (state_ff != pffa_pkg::ST_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_result_page   = rpage_ff;
   assign rsp_result_offset = roff_ff;
   assign rsp_free_total    = ft_ff;

endmodule

### hw/rtl/pffa_checker.sv
// ----------------------------------------------------------------------------
// pffa_checker
// Port-level checks of the allocator's command and response timing.
// ----------------------------------------------------------------------------
module pffa_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_kind,
   input logic        rsp_strobe,
   input logic [1:0]  rsp_status,
   input logic [3:0]  rsp_result_page,
   input logic [11:0] rsp_result_offset
);

   // a response never shows while a command is still running
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while busy");

   // an accepted free never reports an allocation failure
   a_free_status: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind) |-> ##1 (!rsp_strobe || rsp_status != 2'd1))
      else $error("free reported as failed allocate");

   // result fields are zero on every response whose status is not done
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != 2'd0) |->
         (rsp_result_page == 4'd0 && rsp_result_offset == 12'd0))
      else $error("result fields nonzero on failure");

   // status is always a defined code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_status != 2'd3)
      else $error("undefined status code");

endmodule

bind paged_first_fit_allocator_unit pffa_checker u_pffa_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_kind          (req_kind),
   .rsp_strobe        (rsp_strobe),
   .rsp_status        (rsp_status),
   .rsp_result_page   (rsp_result_page),
   .rsp_result_offset (rsp_result_offset)
);
